FILE: hdl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/uard_pkg.sv
// Shared types, constants and helper functions for the radix digit converter.
// No dependencies; imported by every module of the block.
package uard_pkg;

    // Output format selector, as carried by the action field.
    typedef enum logic [1:0] {
        FMT_DEC       = 2'd0,
        FMT_OCT       = 2'd1,
        FMT_HEX_LOWER = 2'd2,
        FMT_HEX_UPPER = 2'd3
    } fmt_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Phases of the shared divide-by-radix unit.
    typedef enum logic [2:0] {
        DV_IDLE,
        DV_SHIFT,
        DV_SEED,
        DV_FOLD,
        DV_TIMES,
        DV_SUB,
        DV_FIX,
        DV_DONE
    } div_phase_t;

    localparam int RADIX_W = 5;

    typedef logic [RADIX_W-1:0] radix_t;
    typedef logic [3:0]         digit_t;
    typedef logic [7:0]         char_t;

    localparam radix_t RADIX_DEC = 5'd10;
    localparam radix_t RADIX_OCT = 5'd8;
    localparam radix_t RADIX_HEX = 5'd16;

    localparam char_t  ASCII_ZERO       = 8'h30;
    localparam char_t  HEX_LOWER_OFFSET = 8'd39;
    localparam char_t  HEX_UPPER_OFFSET = 8'd7;
    localparam digit_t DIGIT_MAX_DEC    = 4'd9;

    // Status that the divider reports to the sequencer.
    typedef struct packed {
        logic   done;
        digit_t rem;
    } div_status_t;

    // Radix that belongs to a format.
    function automatic radix_t radix_of(input fmt_t fmt);
        radix_t r;
        case (fmt)
            FMT_DEC: r = RADIX_DEC;
            FMT_OCT: r = RADIX_OCT;
            default: r = RADIX_HEX;
        endcase
        return r;
    endfunction

    // ASCII code of one digit in the given format.
    function automatic char_t digit_char(input digit_t d, input fmt_t fmt);
        char_t c;
        c = ASCII_ZERO + {4'b0000, d};
        if (d > DIGIT_MAX_DEC) begin
            if (fmt == FMT_HEX_LOWER) begin
                c = c + HEX_LOWER_OFFSET;
            end else begin
                c = c + HEX_UPPER_OFFSET;
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/unsigned_to_ascii_radix_digits.sv
// Unsigned integer to ASCII digits in decimal, octal or hex, most significant first.
// Each digit comes from the shared divide unit (shift and mask for octal and hex, a
// reciprocal estimate for decimal); the first character enters the output register in
// ST_EMIT, after ST_DIV has found the last digit. A new value is taken only in ST_IDLE,
// once the last character of the previous one is loaded, so output stalls hold it off.
// Reset: rst_n clears the sequencer, divider phase and output valid asynchronously.
// Depends on uard_pkg, uard_divider, uard_digit_stack and assert_macros.svh.
`include "assert_macros.svh"

module unsigned_to_ascii_radix_digits #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             action,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             character,
    output logic                   last_char,
    output logic [3:0]             char_count
);
    import uard_pkg::*;

    // Octal needs the most digits at any width.
    localparam int MAX_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);

    state_t state_reg, state_next;
    fmt_t   fmt_reg;
    logic [NDIG_W-1:0] ndig_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    logic        out_valid_reg;
    char_t       char_reg;
    logic        last_reg;
    logic [3:0]  count_reg;

    logic        accept;
    logic        div_start;
    logic        push;
    logic        load_out;
    logic        quot_zero;

    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quotient;
    div_status_t            div_status;
    char_t                  push_char;
    char_t                  stack_char;

    assign accept    = in_valid && in_ready;
    assign quot_zero = (div_quotient == '0);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done && quot_zero) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_out && (rd_idx_reg == '0)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        push      = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                div_start = in_valid;
            end
            ST_DIV: begin
                push      = div_status.done;
                div_start = div_status.done && !quot_zero;
            end
            ST_EMIT: begin
                load_out = !out_valid_reg || out_ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // The first division takes the input value, later ones the last quotient.
    assign div_dividend = (state_reg == ST_IDLE) ? value : div_quotient;
    assign push_char    = digit_char(div_status.rem, fmt_reg);

    uard_divider #(
        .WIDTH (VALUE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (radix_of(fmt_t'(state_reg == ST_IDLE ? action : fmt_reg))),
        .quotient (div_quotient),
        .status   (div_status)
    );

    uard_digit_stack #(
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (push),
        .wr_idx  (ndig_reg[IDX_W-1:0]),
        .wr_data (push_char),
        .rd_idx  (rd_idx_reg),
        .rd_data (stack_char)
    );

    // Sequencer state and digit bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ndig_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                ndig_reg <= '0;
            end else if (push) begin
                ndig_reg <= ndig_reg + 1'b1;
            end
        end
    end

    // Format and read pointer.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            fmt_reg <= fmt_t'(action);
        end
        if (push && quot_zero) begin
            rd_idx_reg <= ndig_reg[IDX_W-1:0];
        end else if (load_out) begin
            rd_idx_reg <= rd_idx_reg - 1'b1;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload, count only on the final character.
    always_ff @(posedge clk)
    begin
        if (load_out) begin
            char_reg  <= stack_char;
            last_reg  <= (rd_idx_reg == '0);
            count_reg <= (rd_idx_reg == '0) ? 4'(ndig_reg) : 4'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign last_char  = last_reg;
    assign char_count = count_reg;

    // Checks on the sequencer and the output framing.
    `ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "input taken while converting")
    `ASSERT_ALWAYS(a_last_has_count, !(out_valid && last_char) || (char_count != 4'd0 || ndig_reg > NDIG_W'(15)), "final character without count")
    `ASSERT_ALWAYS(a_count_only_last, !(out_valid && !last_char) || (char_count == 4'd0), "count on a non-final character")
    `ASSERT_ALWAYS(a_push_in_div, !div_status.done || (state_reg == ST_DIV), "divider finished outside conversion")

endmodule

FILE: hdl/uard_divider.sv
// Shared divide-by-radix unit: octal and hex by shift and mask, decimal by a reciprocal
// estimate built on one shared adder over its seed, fold, times, subtract and fix phases. Depends on uard_pkg.
module uard_divider #(
    parameter int WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  uard_pkg::radix_t     radix,
    output logic [WIDTH-1:0]     quotient,
    output uard_pkg::div_status_t status
);
    import uard_pkg::*;

    localparam logic [1:0] FOLD_LAST = 2'd3;

    div_phase_t       phase_reg, phase_next;
    logic [WIDTH-1:0] num_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] quot_reg;
    radix_t           radix_reg;
    logic [1:0]       fold_reg;
    logic [WIDTH-1:0] add_a;
    logic [WIDTH-1:0] add_b;
    logic             add_sub;
    logic [WIDTH-1:0] add_res;
    logic             rem_big;

    // The shared adder and the remainder range check.
    assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
    assign rem_big = (acc_reg >= WIDTH'(radix_reg));

    // Next phase: decimal runs seed, four folds, times ten, subtract and correction.
    always_comb
    begin
        phase_next = phase_reg;
        if (start)
        begin
            phase_next = (radix == RADIX_DEC) ? DV_SEED : DV_SHIFT;
        end
        else
        begin
            case (phase_reg)
                DV_SHIFT:
                begin
                    phase_next = DV_DONE;
                end
                DV_SEED:
                begin
                    phase_next = DV_FOLD;
                end
                DV_FOLD:
                begin
                    if (fold_reg == FOLD_LAST)
                    begin
                        phase_next = DV_TIMES;
                    end
                end
                DV_TIMES:
                begin
                    phase_next = DV_SUB;
                end
                DV_SUB:
                begin
                    phase_next = DV_FIX;
                end
                DV_FIX:
                begin
                    if (!rem_big)
                    begin
                        phase_next = DV_DONE;
                    end
                end
                default:
                begin
                    phase_next = DV_IDLE;
                end
            endcase
        end
    end

    // Adder operands for each phase. The accumulator approaches 0.8 times the
    // dividend from below, so the quotient estimate is exact or one short.
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = '0;
        add_sub = 1'b0;
        case (phase_reg)
            DV_SEED:
            begin
                add_a = num_reg >> 1;
                add_b = num_reg >> 2;
            end
            DV_FOLD:
            begin
                case (fold_reg)
                    2'd0:    add_b = acc_reg >> 4;
                    2'd1:    add_b = acc_reg >> 8;
                    2'd2:    add_b = acc_reg >> 16;
                    default: add_b = acc_reg >> 32;
                endcase
            end
            DV_TIMES:
            begin
                add_a = (acc_reg >> 3) << 3;
                add_b = (acc_reg >> 3) << 1;
            end
            DV_SUB:
            begin
                add_a   = num_reg;
                add_b   = acc_reg;
                add_sub = 1'b1;
            end
            DV_FIX:
            begin
                add_b   = WIDTH'(radix_reg);
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    // Phase register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DV_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Datapath: the accumulator ends up holding the remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg   <= dividend;
            radix_reg <= radix;
            fold_reg  <= '0;
        end
        else
        begin
            case (phase_reg)
                DV_SHIFT:
                begin
                    // Octal takes three bits per digit, hex four.
                    if (radix_reg == RADIX_OCT)
                    begin
                        quot_reg <= num_reg >> 3;
                        acc_reg  <= WIDTH'(num_reg[2:0]);
                    end
                    else
                    begin
                        quot_reg <= num_reg >> 4;
                        acc_reg  <= WIDTH'(num_reg[3:0]);
                    end
                end
                DV_SEED, DV_SUB:
                begin
                    acc_reg <= add_res;
                end
                DV_FOLD:
                begin
                    acc_reg  <= add_res;
                    fold_reg <= fold_reg + 1'b1;
                end
                DV_TIMES:
                begin
                    acc_reg  <= add_res;
                    quot_reg <= acc_reg >> 3;
                end
                DV_FIX:
                begin
                    if (rem_big)
                    begin
                        acc_reg  <= add_res;
                        quot_reg <= quot_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign quotient    = quot_reg;
    assign status.done = (phase_reg == DV_DONE);
    assign status.rem  = acc_reg[3:0];

endmodule

FILE: hdl/uard_digit_stack.sv
// Register stack that holds the digit characters of one value, least
// significant first, for readout in reverse order. Depends on uard_pkg.
module uard_digit_stack #(
    parameter int DEPTH = 11
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_idx,
    input  uard_pkg::char_t            wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_idx,
    output uard_pkg::char_t            rd_data
);
    import uard_pkg::*;

    char_t slot_reg [DEPTH];

    // Write one character per pushed digit.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = slot_reg[rd_idx];

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for unsigned_to_ascii_radix_digits: feeds values in all four formats and checks
// every emitted character, last flag and count against a digit predictor built in here.
// Depends on uard_pkg and the unsigned_to_ascii_radix_digits RTL.
module tb_top;
    import uard_pkg::*;

    localparam int RANDOM_VALUES = 160;
    localparam int CALM_TAIL     = 30;    // values at the end sent with no idling
    localparam int HOLD_AT       = 60;    // accepted values before the long output hold
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_CYCLES  = 400;   // longer than one full eleven-digit conversion

    localparam char_t CH_ZERO    = 8'h30;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_UPPER_A = 8'h41;

    typedef struct {
        fmt_t        fmt;
        logic [31:0] num;
    } conv_req_t;

    typedef struct {
        char_t      ch;
        logic       last;
        logic [3:0] count;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    fmt_t        action = FMT_DEC;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  character;
    logic        last_char;
    logic [3:0]  char_count;

    conv_req_t  pending_reqs[$];
    text_char_t expected_text[$];
    conv_req_t  next_req;
    text_char_t got_exp;

    int values_total = 0;
    int values_accepted = 0;
    int chars_checked = 0;
    int mismatches = 0;
    int fmt_seen[4] = '{0, 0, 0, 0};
    int stalled_inputs = 0;
    int send_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic idle_on;

    unsigned_to_ascii_radix_digits uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last_char  (last_char),
        .char_count (char_count)
    );

    assign idle_on = (values_accepted < values_total - CALM_TAIL);

    // Work out the digit string of one value, most significant first, and queue it.
    task automatic queue_expected_text(input fmt_t fmt, input logic [31:0] num);
        logic [31:0] rest;
        logic [31:0] base;
        logic [31:0] d;
        char_t       digits[$];
        text_char_t  tc;
        int          n;
        begin
            case (fmt)
                FMT_DEC: base = 32'd10;
                FMT_OCT: base = 32'd8;
                default: base = 32'd16;
            endcase
            rest = num;
            do
            begin
                d = rest % base;
                if (d < 10)
                    digits.push_front(char_t'(CH_ZERO + d));
                else if (fmt == FMT_HEX_LOWER)
                    digits.push_front(char_t'(CH_LOWER_A + d - 10));
                else
                    digits.push_front(char_t'(CH_UPPER_A + d - 10));
                rest = rest / base;
            end
            while (rest != 0);
            n = digits.size();
            for (int k = 0; k < n; k++)
            begin
                tc.ch    = digits[k];
                tc.last  = (k == n - 1);
                tc.count = tc.last ? 4'(n) : 4'd0;
                expected_text.push_back(tc);
            end
            fmt_seen[fmt]++;
        end
    endtask

    task automatic add_req(input fmt_t fmt, input logic [31:0] num);
        conv_req_t r;
        begin
            r.fmt = fmt;
            r.num = num;
            pending_reqs.push_back(r);
        end
    endtask

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Sender: presents queued values, idling in short random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= FMT_DEC;
            value <= '0;
            send_gap <= 0;
            values_accepted <= 0;
        end
        else
        begin
            if (in_valid && !in_ready && hold_left != 0)
                stalled_inputs <= stalled_inputs + 1;
            if (!in_valid || in_ready)
            begin
                // A transfer completes here; predict its text.
                if (in_valid)
                begin
                    queue_expected_text(action, value);
                    values_accepted <= values_accepted + 1;
                end
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (idle_on && pending_reqs.size() != 0 && $urandom_range(0, 4) == 0)
                begin
                    send_gap <= $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    action <= next_req.fmt;
                    value <= next_req.num;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long output hold partway through, so the converter backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && values_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: ready by default, with short random stall bursts and the one long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap <= 0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
        end
        else if (sink_gap != 0)
        begin
            sink_gap <= sink_gap - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            sink_gap <= $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: compare each character transfer with the oldest predicted one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("character: none expected, got %h", character);
                mismatches++;
            end
            else
            begin
                got_exp = expected_text.pop_front();
                chars_checked++;
                if (character !== got_exp.ch)
                begin
                    $error("character: expected %h, got %h", got_exp.ch, character);
                    mismatches++;
                end
                if (last_char !== got_exp.last)
                begin
                    $error("last_char: expected %b, got %b", got_exp.last, last_char);
                    mismatches++;
                end
                if (char_count !== got_exp.count)
                begin
                    $error("char_count: expected %0d, got %0d", got_exp.count, char_count);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        fmt_t f;
        logic [31:0] v;

        // Directed: zero and all-ones in every format, then digit boundaries and mixed-digit hex values.
        for (int i = 0; i < 4; i++)
        begin
            add_req(fmt_t'(i), 32'd0);
            add_req(fmt_t'(i), 32'hFFFF_FFFF);
        end
        add_req(FMT_DEC, 32'd9);
        add_req(FMT_DEC, 32'd10);
        add_req(FMT_DEC, 32'd999_999_999);
        add_req(FMT_DEC, 32'd1_000_000_000);
        add_req(FMT_OCT, 32'd7);
        add_req(FMT_OCT, 32'd8);
        add_req(FMT_OCT, 32'h8000_0000);
        add_req(FMT_HEX_LOWER, 32'd15);
        add_req(FMT_HEX_UPPER, 32'd16);
        add_req(FMT_HEX_LOWER, 32'hABCD_EF01);
        add_req(FMT_HEX_UPPER, 32'hABCD_EF01);
        add_req(FMT_HEX_UPPER, 32'h0123_4567);
        add_req(FMT_DEC, 32'd1);

        // Random: a mix of full-width, shortened, tiny and near power-of-two values.
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            f = fmt_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = $urandom >> $urandom_range(1, 31);
                2: v = $urandom_range(0, 20);
                default: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            endcase
            add_req(f, v);
        end
        values_total = pending_reqs.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_text.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values (dec %0d, oct %0d, hex lower %0d, hex upper %0d).",
                 values_accepted, fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3]);
        $display("Checked %0d characters; input held off for %0d cycles during the long hold.",
                 chars_checked, stalled_inputs);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d values queued and %0d characters outstanding.",
                 pending_reqs.size(), expected_text.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
